// File: sv/rgc_pkg.sv
// Shared types and constants of the grid raycaster column engine.
// No dependencies; every other file of the block but rgc_ram imports this package.
package rgc_pkg;

    // Map geometry: cells are addressed as {y, x}, so both sides are powers of two.
    localparam int MAP_XB     = 5;
    localparam int MAP_YB     = 5;
    localparam int MAP_W      = 1 << MAP_XB;
    localparam int MAP_H      = 1 << MAP_YB;
    localparam int MAP_DEPTH  = MAP_W * MAP_H;
    localparam int MAP_AW     = MAP_XB + MAP_YB;
    localparam int CELL_W     = 4;

    // The walk gives up after this many empty cells.
    localparam int STEP_LIMIT = MAP_W * MAP_H * 2;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 2);

    localparam int TEX_W      = 64;
    localparam int TEX_BITS   = 6;
    localparam int LINE_MAX   = 1 << 20;

    // Shared divider: left-aligned dividend, one quotient bit per cycle.
    localparam int DIV_NW     = 45;
    localparam int DIV_DW     = 34;
    localparam int DIV_CW     = 6;

    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 21;
    localparam int OUT_DW     = 96;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [CFG_IW-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_IW-1:0] REG_HEIGHT  = 3'd7;

    // Input operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef struct packed {
        logic clear;
        logic accept;
        logic ld_cam;
        logic mul_x;
        logic mul_y;
        logic ld_rdy;
        logic start_ddx;
        logic ld_ddx;
        logic start_ddy;
        logic ld_ddy;
        logic mul_sdx;
        logic mul_sdy;
        logic ld_sdy;
        logic step;
        logic check;
        logic start_perp;
        logic ld_perp;
        logic start_lh;
        logic mul_tex;
        logic ld_lh;
        logic load_out;
    } rgc_cmd_t;

    typedef struct packed {
        logic in_op;
        logic div_done;
        logic clear_last;
        logic walk_stop;
        logic out_free;
    } rgc_sts_t;

endpackage

// File: sv/rgc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rgc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/rgc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rgc_pkg for its widths.
module rgc_div import rgc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    input  logic [DIV_CW-1:0] iters,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    // The dividend arrives left-aligned; only its top iters bits are consumed.
    logic [DIV_NW-1:0] num_reg, num_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW+1:0] diff;

    assign shifted = {rem_reg, num_reg[DIV_NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            den_next = divisor;
            cnt_next = iters;
        end
        else if (cnt_reg != '0)
        begin
            num_next = {num_reg[DIV_NW-2:0], 1'b0};
            if (!diff[DIV_DW+1])
            begin
                rem_next = diff[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/rgc_dp.sv
// Datapath of the raycaster: camera registers, ray setup, grid walk, distance,
// slice and texture math, map memory and output register.
// Depends on rgc_pkg, rgc_div and rgc_ram.
module rgc_dp import rgc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                in_op,
    input  logic [MAP_XB-1:0]   in_cell_x,
    input  logic [MAP_YB-1:0]   in_cell_y,
    input  logic [CELL_W-1:0]   in_cell_value,
    input  logic [9:0]          in_column,
    input  rgc_cmd_t            cmd,
    output rgc_sts_t            sts,
    input  logic                out_tready,
    output logic                out_tvalid,
    output logic [OUT_DW-1:0]   out_tdata
);

    // Camera registers.
    logic [20:0] pos_x_reg, pos_y_reg;
    logic [19:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [10:0] width_reg, height_reg;
    logic [10:0] rw_c, rh_c;

    // Ray setup and walk state.
    logic [9:0]          col_reg;
    logic signed [27:0]  cam_reg;
    logic [49:0]         prod_reg;
    logic [33:0]         rdx_reg, rdy_reg;
    logic [50:0]         ddx_reg, ddy_reg;
    logic [62:0]         sdx_reg, sdy_reg;
    logic [12:0]         mx_reg, my_reg;
    logic                side_reg, hit_reg, rd_in_map_reg;
    logic [STEP_W-1:0]   steps_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [31:0]         perp_reg;
    logic [20:0]         lh_reg;
    logic [MAP_AW-1:0]   clr_cnt_reg;
    logic                out_valid_reg;
    logic [OUT_DW-1:0]   out_data_reg;

    always_comb
    begin
        rw_c = width_reg;
        if (width_reg == '0)
        begin
            rw_c = 11'd1;
        end
        else if (width_reg > 11'd1024)
        begin
            rw_c = 11'd1024;
        end
        rh_c = height_reg;
        if (height_reg == '0)
        begin
            rh_c = 11'd1;
        end
        else if (height_reg > 11'd1024)
        begin
            rh_c = 11'd1024;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 21'd98304;
            pos_y_reg   <= 21'd98304;
            dir_x_reg   <= 20'hF0000;
            dir_y_reg   <= 20'd0;
            plane_x_reg <= 20'd0;
            plane_y_reg <= 20'd43253;
            width_reg   <= 11'd320;
            height_reg  <= 11'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_DIR_X:   dir_x_reg   <= cfg_data[19:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_data[19:0];
                REG_PLANE_X: plane_x_reg <= cfg_data[19:0];
                REG_PLANE_Y: plane_y_reg <= cfg_data[19:0];
                REG_WIDTH:   width_reg   <= cfg_data[10:0];
                REG_HEIGHT:  height_reg  <= cfg_data[10:0];
                default:     width_reg   <= width_reg;
            endcase
        end
    end

    // Ray direction helpers.
    logic        rdx_neg, rdy_neg, rdx_zero, rdy_zero;
    logic [33:0] rdx_abs, rdy_abs;
    logic [16:0] fx, fy;

    assign rdx_neg  = rdx_reg[33];
    assign rdy_neg  = rdy_reg[33];
    assign rdx_zero = (rdx_reg == '0);
    assign rdy_zero = (rdy_reg == '0);
    assign rdx_abs  = rdx_neg ? (34'd0 - rdx_reg) : rdx_reg;
    assign rdy_abs  = rdy_neg ? (34'd0 - rdy_reg) : rdy_reg;
    assign fx = rdx_neg ? {1'b0, pos_x_reg[15:0]} : (17'h10000 - {1'b0, pos_x_reg[15:0]});
    assign fy = rdy_neg ? {1'b0, pos_y_reg[15:0]} : (17'h10000 - {1'b0, pos_y_reg[15:0]});

    // One shared multiplier, registered into prod_reg.
    logic signed [32:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [66:0] mul_full;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_x)
        begin
            mul_a = {{13{plane_x_reg[19]}}, plane_x_reg};
            mul_b = {{6{cam_reg[27]}}, cam_reg};
        end
        else if (cmd.mul_y)
        begin
            mul_a = {{13{plane_y_reg[19]}}, plane_y_reg};
            mul_b = {{6{cam_reg[27]}}, cam_reg};
        end
        else if (cmd.mul_sdx)
        begin
            mul_a = {16'd0, fx};
            mul_b = {1'b0, ddx_reg[32:0]};
        end
        else if (cmd.mul_sdy)
        begin
            mul_a = {16'd0, fy};
            mul_b = {1'b0, ddy_reg[32:0]};
        end
        else if (cmd.mul_tex)
        begin
            mul_a = {1'b0, perp_reg};
            mul_b = side_reg ? rdx_reg : rdy_reg;
        end
    end

    assign mul_full = mul_a * mul_b;

    // Distance numerator on the axis of the last step.
    logic [12:0] m_sel;
    logic [20:0] p_sel;
    logic [33:0] ray_sel;
    logic [29:0] num, num_abs;
    logic        perp_special;

    assign m_sel   = side_reg ? my_reg : mx_reg;
    assign p_sel   = side_reg ? pos_y_reg : pos_x_reg;
    assign ray_sel = side_reg ? rdy_reg : rdx_reg;
    assign num     = {m_sel[12], m_sel, 16'd0} - {9'd0, p_sel}
                     + (ray_sel[33] ? 30'h10000 : 30'd0);
    assign num_abs = num[29] ? (30'd0 - num) : num;
    assign perp_special = (ray_sel == '0) || (num == '0) || (num[29] != ray_sel[33]);

    // Divider control.
    logic              div_go, div_done;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_CW-1:0] div_iters;

    assign div_go = (cmd.accept && in_op) || cmd.start_ddx || cmd.start_ddy
                    || cmd.start_perp || cmd.start_lh;

    always_comb
    begin
        div_num   = {in_column, 35'd0};
        div_den   = {23'd0, rw_c};
        div_iters = DIV_CW'(27);
        if (cmd.start_ddx)
        begin
            div_num   = {1'b1, 44'd0};
            div_den   = rdx_abs;
            div_iters = DIV_CW'(33);
        end
        else if (cmd.start_ddy)
        begin
            div_num   = {1'b1, 44'd0};
            div_den   = rdy_abs;
            div_iters = DIV_CW'(33);
        end
        else if (cmd.start_perp)
        begin
            div_num   = {num_abs[28:0], 16'd0};
            div_den   = ray_sel[33] ? (34'd0 - ray_sel) : ray_sel;
            div_iters = DIV_CW'(45);
        end
        else if (cmd.start_lh)
        begin
            div_num   = {rh_c, 34'd0};
            div_den   = {2'd0, perp_reg};
            div_iters = DIV_CW'(27);
        end
    end

    rgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_num),
        .divisor  (div_den),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Grid walk step and map memory.
    logic              x_go, nx_in;
    logic [12:0]       mx_step, my_step, nx, ny;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata, cell_now;

    assign x_go    = (sdx_reg < sdy_reg);
    assign mx_step = rdx_neg ? (mx_reg - 13'd1) : (mx_reg + 13'd1);
    assign my_step = rdy_neg ? (my_reg - 13'd1) : (my_reg + 13'd1);
    assign nx      = x_go ? mx_step : mx_reg;
    assign ny      = x_go ? my_reg : my_step;
    assign nx_in   = !nx[12] && (nx[11:0] < 12'(MAP_W)) && !ny[12] && (ny[11:0] < 12'(MAP_H));

    assign ram_we    = cmd.clear || (cmd.accept && (in_op == OP_WRITE));
    assign ram_waddr = cmd.clear ? clr_cnt_reg : {in_cell_y, in_cell_x};
    assign ram_wdata = cmd.clear ? '0 : in_cell_value;
    assign ram_raddr = {ny[MAP_YB-1:0], nx[MAP_XB-1:0]};

    rgc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cells outside the map read as empty.
    assign cell_now = rd_in_map_reg ? ram_rdata : '0;

    // Slice and texture results.
    logic [9:0]          rh_half, ds, de;
    logic [19:0]         lh_half;
    logic [20:0]         de_sum;
    logic [15:0]         frac;
    logic [TEX_BITS-1:0] tx;
    logic                tx_flip;
    logic [1:0]          tnum;

    assign rh_half = rh_c[10:1];
    assign lh_half = lh_reg[20:1];
    assign ds      = ({10'd0, rh_half} > lh_half) ? (rh_half - lh_half[9:0]) : 10'd0;
    assign de_sum  = {1'b0, lh_half} + {11'd0, rh_half};
    assign de      = (de_sum >= {10'd0, rh_c}) ? 10'(rh_c - 11'd1) : de_sum[9:0];
    assign frac    = (side_reg ? pos_x_reg[15:0] : pos_y_reg[15:0]) + prod_reg[31:16];
    assign tx_flip = side_reg ? rdy_neg : (!rdx_neg && !rdx_zero);
    assign tx      = tx_flip ? ~frac[15 -: TEX_BITS] : frac[15 -: TEX_BITS];
    assign tnum    = ((cell_reg >= 4'd1) && (cell_reg <= 4'd3)) ? cell_reg[1:0] : 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.ld_sdy)
            begin
                hit_reg   <= 1'b0;
                steps_reg <= '0;
            end
            else if (cmd.check)
            begin
                if (cell_now != '0)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
            end
        end
    end

    // For a zero ray the first side distance is frac * 2^50 / 2^16 taken modulo
    // 2^64 before the shift, so only the low 14 bits of frac survive.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_op)
        begin
            col_reg <= in_column;
        end
        if (cmd.ld_cam)
        begin
            cam_reg <= div_quo[27:0] - 28'd65536;
        end
        if (cmd.mul_x || cmd.mul_y || cmd.mul_sdx || cmd.mul_sdy || cmd.mul_tex)
        begin
            prod_reg <= mul_full[49:0];
        end
        if (cmd.mul_y)
        begin
            rdx_reg <= {{14{dir_x_reg[19]}}, dir_x_reg} + prod_reg[49:16];
        end
        if (cmd.ld_rdy)
        begin
            rdy_reg <= {{14{dir_y_reg[19]}}, dir_y_reg} + prod_reg[49:16];
        end
        if (cmd.ld_ddx)
        begin
            ddx_reg <= rdx_zero ? {1'b1, 50'd0} : {18'd0, div_quo[32:0]};
        end
        if (cmd.ld_ddy)
        begin
            ddy_reg <= rdy_zero ? {1'b1, 50'd0} : {18'd0, div_quo[32:0]};
        end
        if (cmd.mul_sdy)
        begin
            sdx_reg <= rdx_zero ? {15'd0, fx[13:0], 34'd0} : {30'd0, prod_reg[48:16]};
        end
        if (cmd.ld_sdy)
        begin
            sdy_reg  <= rdy_zero ? {15'd0, fy[13:0], 34'd0} : {30'd0, prod_reg[48:16]};
            mx_reg   <= {8'd0, pos_x_reg[20:16]};
            my_reg   <= {8'd0, pos_y_reg[20:16]};
            side_reg <= 1'b0;
            cell_reg <= '0;
        end
        if (cmd.step)
        begin
            rd_in_map_reg <= nx_in;
            mx_reg        <= nx;
            my_reg        <= ny;
            side_reg      <= !x_go;
            if (x_go)
            begin
                sdx_reg <= sdx_reg + {12'd0, ddx_reg};
            end
            else
            begin
                sdy_reg <= sdy_reg + {12'd0, ddy_reg};
            end
        end
        if (cmd.check)
        begin
            cell_reg <= cell_now;
        end
        if (cmd.ld_perp)
        begin
            if (perp_special || (div_quo == '0))
            begin
                perp_reg <= 32'd1;
            end
            else if (div_quo[DIV_NW-1:32] != '0)
            begin
                perp_reg <= 32'hFFFF_FFFF;
            end
            else
            begin
                perp_reg <= div_quo[31:0];
            end
        end
        if (cmd.ld_lh)
        begin
            if (div_quo == '0)
            begin
                lh_reg <= {10'd0, rh_c};
            end
            else if (div_quo > DIV_NW'(LINE_MAX))
            begin
                lh_reg <= 21'(LINE_MAX);
            end
            else
            begin
                lh_reg <= div_quo[20:0];
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {3'd0, tx, tnum, de, ds, lh_reg, perp_reg, side_reg, hit_reg,
                             col_reg};
        end
    end

    assign sts.in_op      = in_op;
    assign sts.div_done   = div_done;
    assign sts.clear_last = (clr_cnt_reg == MAP_AW'(MAP_DEPTH - 1));
    assign sts.walk_stop  = (cell_now != '0) || (steps_reg == STEP_W'(STEP_LIMIT));
    assign sts.out_free   = !out_valid_reg || out_tready;

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

    // A walk marked as a hit always ends on a wall cell.
    a_hit_on_wall: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (cell_reg != '0))
        else $error("hit flag set without a wall cell");

    // The distance is never zero, so the slice division is always defined.
    a_perp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_perp |=> (perp_reg != '0))
        else $error("wall distance loaded as zero");

endmodule

// File: sv/rgc_ctrl.sv
// Sequencer of the raycaster: clear pass, input handshake and the cast sequence.
// Depends on rgc_pkg for the command and status structs.
module rgc_ctrl import rgc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rgc_sts_t sts,
    output rgc_cmd_t cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_CAM   = 5'd2;
    localparam logic [4:0] S_MULX  = 5'd3;
    localparam logic [4:0] S_MULY  = 5'd4;
    localparam logic [4:0] S_RAYY  = 5'd5;
    localparam logic [4:0] S_DDX   = 5'd6;
    localparam logic [4:0] S_DDY   = 5'd7;
    localparam logic [4:0] S_SDX   = 5'd8;
    localparam logic [4:0] S_SDY   = 5'd9;
    localparam logic [4:0] S_SDY2  = 5'd10;
    localparam logic [4:0] S_STEP  = 5'd11;
    localparam logic [4:0] S_CHECK = 5'd12;
    localparam logic [4:0] S_NUM   = 5'd13;
    localparam logic [4:0] S_PERP  = 5'd14;
    localparam logic [4:0] S_LHS   = 5'd15;
    localparam logic [4:0] S_LH    = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && (sts.in_op == OP_CAST))
                begin
                    state_next = S_CAM;
                end
            end
            S_CAM:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_cam = 1'b1;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_RAYY;
            end
            S_RAYY:
            begin
                cmd.ld_rdy    = 1'b1;
                cmd.start_ddx = 1'b1;
                state_next    = S_DDX;
            end
            S_DDX:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_ddx    = 1'b1;
                    cmd.start_ddy = 1'b1;
                    state_next    = S_DDY;
                end
            end
            S_DDY:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_ddy = 1'b1;
                    state_next = S_SDX;
                end
            end
            S_SDX:
            begin
                cmd.mul_sdx = 1'b1;
                state_next  = S_SDY;
            end
            S_SDY:
            begin
                cmd.mul_sdy = 1'b1;
                state_next  = S_SDY2;
            end
            S_SDY2:
            begin
                cmd.ld_sdy = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.walk_stop ? S_NUM : S_STEP;
            end
            S_NUM:
            begin
                cmd.start_perp = 1'b1;
                state_next     = S_PERP;
            end
            S_PERP:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_perp = 1'b1;
                    state_next  = S_LHS;
                end
            end
            S_LHS:
            begin
                cmd.start_lh = 1'b1;
                cmd.mul_tex  = 1'b1;
                state_next   = S_LH;
            end
            S_LH:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_lh  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every map read issued by a step is checked in the following cycle.
    a_step_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> cmd.check)
        else $error("walk step not followed by a cell check");

    // A result is never loaded over one that has not been taken.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten");

    // A cast item always starts the camera division.
    a_cast_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (sts.in_op == OP_CAST)) |=> (state_reg == S_CAM))
        else $error("cast item did not start the ray setup");

endmodule

// File: sv/grid_raycast_wall_column.sv
// Grid raycaster, one wall column per cast item.
// Channels: the s_ group takes items; s_tuser is the operation (0 writes one map
// cell, 1 casts one screen column). A write takes effect in the cycle it is taken
// and gives no result. A cast gives one result item on the m_ group.
// The cfg_ port writes the camera registers; write only while the block is idle.
// The time a cast takes is set by the one shared divider, which produces one
// quotient bit per cycle for five divisions per column, and by the registered read
// of the map memory, which splits each walk step into a step and a check state.
// One cast is in work at a time; the next item is taken once the result is in the
// output register, even if the receiver has not taken that result yet.
// If the receiver stalls, the finished result waits in the output register and a
// second cast waits before its last cycle until the register frees up.
// After reset the map memory is cleared, all 1024 cells, one cell a cycle; items
// are not taken meanwhile, but configuration writes are. The camera registers
// come out of reset with their default view.
// Depends on rgc_pkg, rgc_ctrl, rgc_dp, rgc_div and rgc_ram.
module grid_raycast_wall_column import rgc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // cell_x[4:0], cell_y[9:5], cell_value[13:10],
                                          // column[23:14]
    input  logic               s_tuser,   // op[0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_DW-1:0]  m_tdata,   // column_out[9:0], hit[10], side[11],
                                          // wall_dist[43:12], line_height[64:44],
                                          // draw_start[74:65], draw_end[84:75],
                                          // tex_num[86:85], tex_x[92:87], zeros above
    input  logic               cfg_we,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data
);

    rgc_cmd_t cmd;
    rgc_sts_t sts;

    // The controller owns the handshake on the input side.
    rgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the camera, the map, the walk and the result register.
    rgc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_op         (s_tuser),
        .in_cell_x     (s_tdata[4:0]),
        .in_cell_y     (s_tdata[9:5]),
        .in_cell_value (s_tdata[13:10]),
        .in_column     (s_tdata[23:14]),
        .cmd           (cmd),
        .sts           (sts),
        .out_tready    (m_tready),
        .out_tvalid    (m_tvalid),
        .out_tdata     (m_tdata)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the grid raycaster column engine.
// Depends on rgc_pkg and grid_raycast_wall_column; a built-in column predictor
// checks every result item against the expected column results.
module tb_top;
    import rgc_pkg::*;

    // Fields of one result item, declared from the top of m_tdata down, so that
    // column_out sits in the lowest bits.
    typedef struct packed {
        logic [5:0]  tex_x;
        logic [1:0]  tex_num;
        logic [9:0]  draw_end;
        logic [9:0]  draw_start;
        logic [20:0] line_height;
        logic [31:0] wall_dist;
        logic        side;
        logic        hit;
        logic [9:0]  column_out;
    } column_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_DW-1:0]  m_tdata;
    logic               cfg_we;
    logic [CFG_IW-1:0]  cfg_index;
    logic [CFG_DW-1:0]  cfg_data;

    grid_raycast_wall_column u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a private copy of the map and of the camera registers.
    logic [3:0]   shadow_map [MAP_DEPTH];
    logic [20:0]  cam_pos_x, cam_pos_y;
    logic [19:0]  cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
    logic [10:0]  scr_width, scr_height;

    column_result_t pending_columns [$];
    int unsigned    error_count;

    // Idle rates in percent; the receiver stall switch is forced by the
    // back-pressure test.
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             recv_hold;
    bit             timed_out;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Floor division by 65536, rounding toward minus infinity.
    function automatic longint floor_div_q16(longint v);
        if (v >= 0)
            return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic longint dim_of(logic [10:0] v);
        if (v == 0)
            return 1;
        if (v > 1024)
            return 1024;
        return longint'(v);
    endfunction

    function automatic logic [3:0] map_at(longint x, longint y);
        if (x < 0 || x >= MAP_W || y < 0 || y >= MAP_H)
            return 4'd0;
        return shadow_map[y * MAP_W + x];
    endfunction

    // Walks one ray through the shadow map and derives the wall slice.
    function automatic column_result_t cast_column(logic [9:0] col);
        column_result_t r;
        longint rw, rh, px, py, cam, rdx, rdy, mx, my, stx, sty;
        longint num, ray, q, lh, ds, de, other, w;
        longint unsigned ddx, ddy, sdx, sdy, fx, fy, perp, tx;
        logic [3:0] val;
        int steps;
        bit found, side;
        rw = dim_of(scr_width);
        rh = dim_of(scr_height);
        px = longint'(cam_pos_x);
        py = longint'(cam_pos_y);
        cam = (longint'(col) * 2 * 65536) / rw - 65536;
        rdx = longint'($signed(cam_dir_x)) + floor_div_q16(longint'($signed(cam_plane_x)) * cam);
        rdy = longint'($signed(cam_dir_y)) + floor_div_q16(longint'($signed(cam_plane_y)) * cam);
        mx = px / 65536;
        my = py / 65536;
        ddx = (rdx == 0) ? (64'd1 << 50) : (64'd1 << 32) / longint'(rdx < 0 ? -rdx : rdx);
        ddy = (rdy == 0) ? (64'd1 << 50) : (64'd1 << 32) / longint'(rdy < 0 ? -rdy : rdy);
        if (rdx < 0)
        begin
            stx = -1;
            fx = px & 16'hFFFF;
        end
        else
        begin
            stx = 1;
            fx = 65536 - (px & 16'hFFFF);
        end
        if (rdy < 0)
        begin
            sty = -1;
            fy = py & 16'hFFFF;
        end
        else
        begin
            sty = 1;
            fy = 65536 - (py & 16'hFFFF);
        end
        sdx = (fx * ddx) >> 16;
        sdy = (fy * ddy) >> 16;
        steps = 0;
        found = 0;
        side = 0;
        forever
        begin
            if (sdx < sdy)
            begin
                sdx += ddx;
                mx += stx;
                side = 0;
            end
            else
            begin
                sdy += ddy;
                my += sty;
                side = 1;
            end
            if (map_at(mx, my) != 0)
            begin
                found = 1;
                break;
            end
            steps++;
            if (steps > STEP_LIMIT)
                break;
        end
        if (side == 0)
        begin
            ray = rdx;
            num = mx * 65536 - px + (stx < 0 ? 65536 : 0);
        end
        else
        begin
            ray = rdy;
            num = my * 65536 - py + (sty < 0 ? 65536 : 0);
        end
        if (ray == 0)
            perp = 1;
        else
        begin
            q = (num * 65536) / ray;
            if (q <= 0)
                perp = 1;
            else if (q > 64'hFFFF_FFFF)
                perp = 64'hFFFF_FFFF;
            else
                perp = q;
        end
        lh = (rh * 65536) / longint'(perp);
        if (lh <= 0)
            lh = rh;
        if (lh > LINE_MAX)
            lh = LINE_MAX;
        ds = rh / 2 - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + rh / 2;
        if (de >= rh)
            de = rh - 1;
        val = map_at(mx, my);
        if (side == 0)
        begin
            other = py;
            ray = rdy;
        end
        else
        begin
            other = px;
            ray = rdx;
        end
        w = other + floor_div_q16(longint'(perp) * ray);
        tx = ((w & 16'hFFFF) * TEX_W) >> 16;
        if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
            tx = TEX_W - tx - 1;
        r.column_out  = col;
        r.hit         = found;
        r.side        = side;
        r.wall_dist   = perp[31:0];
        r.line_height = lh[20:0];
        r.draw_start  = ds[9:0];
        r.draw_end    = de[9:0];
        r.tex_num     = (val >= 1 && val <= 3) ? val[1:0] : 2'd1;
        r.tex_x       = tx[5:0];
        return r;
    endfunction

    // Sends one item and, once accepted, updates the shadow state or queues
    // the expected column result. Valid stays high between back-to-back items
    // and drops only while the sender idles or drains.
    task automatic send_item(logic op, logic [4:0] cx, logic [4:0] cy,
                             logic [3:0] cv, logic [9:0] col);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, cv, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_WRITE)
            shadow_map[{cy, cx}] = cv;
        else
            pending_columns.push_back(cast_column(col));
    endtask

    task automatic write_cell(int x, int y, int v);
        send_item(OP_WRITE, x[4:0], y[4:0], v[3:0], 10'd0);
    endtask

    task automatic cast(int col);
        send_item(OP_CAST, 5'd0, 5'd0, 4'd0, col[9:0]);
    endtask

    task automatic random_item();
        int kind;
        kind = $urandom_range(99);
        if (kind < 30)
            send_item(OP_WRITE, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      4'($urandom_range(15)), 10'($urandom_range(1023)));
        else if (kind < 95)
            send_item(OP_CAST, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      4'($urandom_range(15)),
                      10'($urandom_range(int'(dim_of(scr_width)) - 1)));
        else
            send_item(OP_CAST, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      4'($urandom_range(15)), 10'($urandom_range(1023)));
    endtask

    // Drops valid, waits until every expected result has come back, then lets
    // the shared divider and walk settle before the next register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_POS_X:   cam_pos_x   = value;
            REG_POS_Y:   cam_pos_y   = value;
            REG_DIR_X:   cam_dir_x   = value[19:0];
            REG_DIR_Y:   cam_dir_y   = value[19:0];
            REG_PLANE_X: cam_plane_x = value[19:0];
            REG_PLANE_Y: cam_plane_y = value[19:0];
            REG_WIDTH:   scr_width   = value[10:0];
            default:     scr_height  = value[10:0];
        endcase
    endtask

    task automatic set_camera(int x, int y, int dx, int dy, int plx, int ply,
                              int w, int h);
        write_reg(REG_POS_X, CFG_DW'(x));
        write_reg(REG_POS_Y, CFG_DW'(y));
        write_reg(REG_DIR_X, CFG_DW'(dx));
        write_reg(REG_DIR_Y, CFG_DW'(dy));
        write_reg(REG_PLANE_X, CFG_DW'(plx));
        write_reg(REG_PLANE_Y, CFG_DW'(ply));
        write_reg(REG_WIDTH, CFG_DW'(w));
        write_reg(REG_HEIGHT, CFG_DW'(h));
        cfg_we <= 1'b0;
    endtask

    // Directed part: wall types, edge columns, open sky, writes off the wall.
    task automatic test_directed();
        for (int i = 0; i < 32; i += 31)
            for (int j = 0; j < 32; j++)
            begin
                if (j % 8 == 0)
                begin
                    write_cell(i, j, (j / 8) + 1);
                    write_cell(j, i, 15);
                end
            end
        cast(0);
        cast(160);
        cast(319);
        cast(1023);
        write_cell(0, 1, 3);
        write_cell(5, 5, 0);
        cast(1);
        drain();
        // Facing along +x from the right edge of the map: the walk leaves the map.
        set_camera(32'h1F_FFFF, 0, 32'h7FFFF, 0, 0, 32'h80000, 1024, 1024);
        cast(0);
        cast(512);
        cast(1023);
        drain();
        set_camera(98304, 98304, 0, 0, 0, 0, 0, 0);
        cast(0);
        cast(1023);
        drain();
        set_camera(20 * 65536 + 1, 7 * 65536 + 32768, 32'h80000, 32'h10000,
                   32'h08000, 32'h7FFFF, 1, 2047);
        cast(0);
        cast(700);
        drain();
    endtask

    // Random configuration with extremes now and then.
    task automatic random_camera();
        set_camera($urandom_range(32 * 65536 - 1), $urandom_range(32 * 65536 - 1),
                   $urandom_range(32'hFFFFF), $urandom_range(32'hFFFFF),
                   $urandom_range(32'hFFFFF), $urandom_range(32'hFFFFF),
                   $urandom_range(3) == 0 ? $urandom_range(2047) : $urandom_range(1, 400),
                   $urandom_range(3) == 0 ? $urandom_range(2047) : $urandom_range(1, 400));
    endtask

    task automatic test_random(int items);
        for (int k = 0; k < items; k++)
        begin
            if (k % 150 == 0)
            begin
                drain();
                random_camera();
            end
            random_item();
        end
        drain();
    endtask

    // The receiver holds off while casts pile up, then the sender waits
    // for every result before going on.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_hold = 1;
        fork
            begin
                repeat (2000) @(posedge clk);
                recv_hold = 0;
            end
            for (int k = 0; k < 6; k++)
                cast($urandom_range(int'(dim_of(scr_width)) - 1));
        join
        drain();
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        column_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[92:0];
            if (pending_columns.size() == 0)
            begin
                $error("result item with no cast pending: %h", got);
                error_count++;
            end
            else
            begin
                want = pending_columns.pop_front();
                if (got.column_out != want.column_out)
                    $error("column_out exp %0d got %0d", want.column_out, got.column_out);
                if (got.hit != want.hit)
                    $error("hit exp %0d got %0d", want.hit, got.hit);
                if (got.side != want.side)
                    $error("side exp %0d got %0d", want.side, got.side);
                if (got.wall_dist != want.wall_dist)
                    $error("wall_dist exp %0d got %0d", want.wall_dist, got.wall_dist);
                if (got.line_height != want.line_height)
                    $error("line_height exp %0d got %0d", want.line_height, got.line_height);
                if (got.draw_start != want.draw_start)
                    $error("draw_start exp %0d got %0d", want.draw_start, got.draw_start);
                if (got.draw_end != want.draw_end)
                    $error("draw_end exp %0d got %0d", want.draw_end, got.draw_end);
                if (got.tex_num != want.tex_num)
                    $error("tex_num exp %0d got %0d", want.tex_num, got.tex_num);
                if (got.tex_x != want.tex_x)
                    $error("tex_x exp %0d got %0d", want.tex_x, got.tex_x);
                if (got != want)
                    error_count++;
            end
        end
    end

    // Receiver ready, random stalls at the current rate.
    always @(posedge clk)
    begin
        if (recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #500_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        recv_hold = 0;
        send_idle_pct = 37;
        recv_idle_pct = 49;
        foreach (shadow_map[i])
            shadow_map[i] = 4'd0;
        cam_pos_x = 21'd98304;
        cam_pos_y = 21'd98304;
        cam_dir_x = 20'hF0000;
        cam_dir_y = '0;
        cam_plane_x = '0;
        cam_plane_y = 20'd43253;
        scr_width = 11'd320;
        scr_height = 11'd200;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(500);
        send_idle_pct = 49;
        recv_idle_pct = 37;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        test_backpressure();

        drain();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: sim.f
sv/rgc_pkg.sv
sv/rgc_ram.sv
sv/rgc_div.sv
sv/rgc_dp.sv
sv/rgc_ctrl.sv
sv/grid_raycast_wall_column.sv
tb/sv/tb_top.sv
